@@ sv/bbalc_pkg.sv @@
// Shared types and constants of the bitmap block allocator.
`default_nettype none

package bbalc_pkg;

  // Block numbers are 10 bits wide, so at most 1024 blocks can ever be granted.
  localparam int BLK_W       = 10;
  localparam int CNT_W       = 11;
  localparam int BLOCK_LIMIT = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT = 2'd1;

  localparam logic [BLK_W-1:0] DATA_START_RST = 10'd10;
  localparam logic [CNT_W-1:0] DATA_COUNT_RST = 11'd1014;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_WR,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

@@ sv/bbalc_req_if.sv @@
// Request channel of the allocator: request type and block number.
`default_nettype none

interface bbalc_req_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [bbalc_pkg::BLK_W-1:0] block_num;

  modport source (output valid, output req_type, output block_num, input ready);
  modport sink   (input valid, input req_type, input block_num, output ready);
endinterface

`default_nettype wire

@@ sv/bbalc_rsp_if.sv @@
// Result channel of the allocator: status and granted block number.
`default_nettype none

interface bbalc_rsp_if;
  logic                        valid;
  logic                        ready;
  bbalc_pkg::status_t          status;
  logic [bbalc_pkg::BLK_W-1:0] granted_block;

  modport source (output valid, output status, output granted_block, input ready);
  modport sink   (input valid, input status, input granted_block, output ready);
endinterface

`default_nettype wire

@@ sv/bbalc_cfg_if.sv @@
// Register write channel of the allocator.
`default_nettype none

interface bbalc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bbalc_pkg::CFG_IDX_W-1:0]  index;
  logic [bbalc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/bitmap_block_allocator_top.sv @@
// First-fit bitmap block allocator: free map in one synchronous memory.
//
// Requests arrive on in_chan (req_type 0 allocates, 1 frees block_num), and
// every request yields exactly one result on out_chan: a status and, for a
// successful allocate, the granted block number. cfg_chan writes data_start
// (index 0) and data_count (index 1); writes to other indexes are dropped.
// The free map holds one bit per block in a memory of MAP_WORDS words.
// After reset the block clears the memory, one word per cycle, through all
// MAP_WORDS words (32 with the default parameters) before it takes the first request.
// One request is worked on at a time. An allocate reads one map word per
// cycle from word 0 upward, at most MAP_WORDS words (32 by default); its
// result is registered once a clear tracked bit is found or the last
// tracked word has been read, and only then can the next request be taken;
// the single memory read port sets this rate.
// A free goes through three steps: quotient, word read, write back. An allocate
// with nothing tracked or a free out of range goes straight to its result.
// Results sit in an output register; while it is full and out_chan is not
// ready, the block finishes nothing new, but it takes the next request.
`default_nettype none

module bitmap_block_allocator_top #(
  parameter int TOTAL_BLOCKS = 1024,
  parameter int WORD_BITS    = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  bbalc_req_if.sink         in_chan,
  bbalc_rsp_if.source       out_chan,
  bbalc_cfg_if.sink         cfg_chan
);

  localparam int BLK_W     = bbalc_pkg::BLK_W;
  localparam int CNT_W     = bbalc_pkg::CNT_W;
  localparam int MAP_WORDS = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int CAP       = (TOTAL_BLOCKS < bbalc_pkg::BLOCK_LIMIT) ?
                             TOTAL_BLOCKS : bbalc_pkg::BLOCK_LIMIT;
  // Reciprocal of WORD_BITS for the word index of a freed block.
  localparam int QSH       = 20;
  localparam int RECIP_W   = 21;
  localparam int RECIP     = ((1 << QSH) + WORD_BITS - 1) / WORD_BITS;

  // Free map memory.
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= map_mem[rd_addr];
    end
  end

  // Registers.
  bbalc_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]        clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]        chk_addr_r, chk_addr_nxt;
  logic [CNT_W-1:0]     base_r, base_nxt;
  logic [BLK_W-1:0]     rel_r, rel_nxt;
  logic [BLK_W-1:0]     quot_r, quot_nxt;
  logic [BIT_W-1:0]     bit_r, bit_nxt;
  bbalc_pkg::status_t   resp_stat_r, resp_stat_nxt;
  logic [BLK_W-1:0]     data_start_r;
  logic [CNT_W-1:0]     data_count_r;
  logic                 out_valid_r, out_valid_nxt;
  bbalc_pkg::status_t   out_status_r, out_status_nxt;
  logic [BLK_W-1:0]     out_grant_r, out_grant_nxt;

  // Configuration writes.
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_start_r <= bbalc_pkg::DATA_START_RST;
      data_count_r <= bbalc_pkg::DATA_COUNT_RST;
    end else if (cfg_chan.valid) begin
      if (cfg_chan.index == bbalc_pkg::CFG_DATA_START) begin
        data_start_r <= cfg_chan.data[BLK_W-1:0];
      end else if (cfg_chan.index == bbalc_pkg::CFG_DATA_COUNT) begin
        data_count_r <= cfg_chan.data[CNT_W-1:0];
      end
    end
  end

  // Tracked count: data_count limited by the map size and by the block field.
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] tracked;

  always_comb begin
    room    = CNT_W'(bbalc_pkg::BLOCK_LIMIT) - {1'b0, data_start_r};
    tracked = data_count_r;
    if (tracked > CNT_W'(CAP)) begin
      tracked = CNT_W'(CAP);
    end
    if (tracked > room) begin
      tracked = room;
    end
  end

  // Free request decode.
  logic [BLK_W-1:0]         rel;
  logic                     in_range;
  logic [BLK_W+RECIP_W-1:0] qprod;

  assign rel      = in_chan.block_num - data_start_r;
  assign in_range = (in_chan.block_num >= data_start_r) && ({1'b0, rel} < tracked);
  assign qprod    = {{RECIP_W{1'b0}}, rel} * (BLK_W + RECIP_W)'(RECIP);

  logic [2*BLK_W-1:0] qmul;
  logic [BLK_W-1:0]   rem;
  logic [AW+BLK_W-1:0] quot_ext;
  logic [AW-1:0]      free_addr;

  assign qmul      = quot_r * BLK_W'(WORD_BITS);
  assign rem       = rel_r - qmul[BLK_W-1:0];
  assign quot_ext  = {{AW{1'b0}}, quot_r};
  assign free_addr = quot_ext[AW-1:0];

  // Allocate scan over the current word.
  logic [CNT_W-1:0] remaining;
  logic             last_word;
  logic             found;
  logic [BIT_W-1:0] pick_bit;

  assign remaining = tracked - base_r;
  assign last_word = remaining <= CNT_W'(WORD_BITS);

  bbalc_pick #(
    .WORD_BITS (WORD_BITS),
    .BIT_W     (BIT_W)
  ) u_pick (
    .word     (rdata_r),
    .limit    (remaining),
    .found    (found),
    .pick_bit (pick_bit)
  );

  logic [WORD_BITS-1:0] pick_mask;
  logic [WORD_BITS-1:0] free_mask;
  logic [BLK_W-1:0]     grant;

  assign pick_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << pick_bit;
  assign free_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_r;
  assign grant     = data_start_r + base_r[BLK_W-1:0] +
                     {{(BLK_W-BIT_W){1'b0}}, pick_bit};

  logic can_load;

  assign can_load = !out_valid_r || out_chan.ready;

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    chk_addr_nxt   = chk_addr_r;
    base_nxt       = base_r;
    rel_nxt        = rel_r;
    quot_nxt       = quot_r;
    bit_nxt        = bit_r;
    resp_stat_nxt  = resp_stat_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_grant_nxt  = out_grant_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    in_chan.ready  = 1'b0;

    unique case (state_r)
      bbalc_pkg::S_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = bbalc_pkg::S_IDLE;
        end
      end

      bbalc_pkg::S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          if (in_chan.req_type == bbalc_pkg::REQ_ALLOC) begin
            if (tracked == '0) begin
              resp_stat_nxt = bbalc_pkg::STAT_FULL;
              state_nxt     = bbalc_pkg::S_RESP;
            end else begin
              rd_en        = 1'b1;
              rd_addr      = '0;
              chk_addr_nxt = '0;
              base_nxt     = '0;
              state_nxt    = bbalc_pkg::S_SCAN;
            end
          end else if (!in_range) begin
            resp_stat_nxt = bbalc_pkg::STAT_RANGE;
            state_nxt     = bbalc_pkg::S_RESP;
          end else begin
            rel_nxt   = rel;
            quot_nxt  = qprod[QSH +: BLK_W];
            state_nxt = bbalc_pkg::S_FREE_RD;
          end
        end
      end

      bbalc_pkg::S_SCAN: begin
        if (found) begin
          if (can_load) begin
            wr_en          = 1'b1;
            wr_addr        = chk_addr_r;
            wr_data        = rdata_r | pick_mask;
            out_valid_nxt  = 1'b1;
            out_status_nxt = bbalc_pkg::STAT_OK;
            out_grant_nxt  = grant;
            state_nxt      = bbalc_pkg::S_IDLE;
          end
        end else if (last_word) begin
          if (can_load) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bbalc_pkg::STAT_FULL;
            out_grant_nxt  = '0;
            state_nxt      = bbalc_pkg::S_IDLE;
          end
        end else begin
          rd_en        = 1'b1;
          rd_addr      = chk_addr_r + 1'b1;
          chk_addr_nxt = chk_addr_r + 1'b1;
          base_nxt     = base_r + CNT_W'(WORD_BITS);
        end
      end

      bbalc_pkg::S_FREE_RD: begin
        rd_en     = 1'b1;
        rd_addr   = free_addr;
        bit_nxt   = rem[BIT_W-1:0];
        state_nxt = bbalc_pkg::S_FREE_WR;
      end

      bbalc_pkg::S_FREE_WR: begin
        if (can_load) begin
          wr_en          = 1'b1;
          wr_addr        = free_addr;
          wr_data        = rdata_r & ~free_mask;
          out_valid_nxt  = 1'b1;
          out_status_nxt = bbalc_pkg::STAT_OK;
          out_grant_nxt  = '0;
          state_nxt      = bbalc_pkg::S_IDLE;
        end
      end

      bbalc_pkg::S_RESP: begin
        if (can_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = resp_stat_r;
          out_grant_nxt  = '0;
          state_nxt      = bbalc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bbalc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bbalc_pkg::S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r   <= chk_addr_nxt;
    base_r       <= base_nxt;
    rel_r        <= rel_nxt;
    quot_r       <= quot_nxt;
    bit_r        <= bit_nxt;
    resp_stat_r  <= resp_stat_nxt;
    out_status_r <= out_status_nxt;
    out_grant_r  <= out_grant_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.granted_block = out_grant_r;

endmodule

`default_nettype wire

@@ sv/bbalc_pick.sv @@
// Lowest clear bit finder over one map word, limited to the tracked bits.
`default_nettype none

module bbalc_pick #(
  parameter int WORD_BITS = 32,
  parameter int BIT_W     = $clog2(WORD_BITS)
) (
  input  wire logic [WORD_BITS-1:0]        word,
  input  wire logic [bbalc_pkg::CNT_W-1:0] limit,
  output logic                             found,
  output logic [BIT_W-1:0]                 pick_bit
);

  // Scan from the top down so the lowest eligible bit wins.
  always_comb begin
    found    = 1'b0;
    pick_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!word[b] && (bbalc_pkg::CNT_W'(b) < limit)) begin
        found    = 1'b1;
        pick_bit = BIT_W'(b);
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/bbalc_checker.sv @@
// Watches the allocator's channels, keeps its own free map and checks every result.
`timescale 1ns / 1ps

module bbalc_checker
  import bbalc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  bbalc_req_if  req,
  bbalc_rsp_if  rsp,
  bbalc_cfg_if  cfg,
  output int    mismatches,
  output int    outstanding
);

  // Map size of the block as instantiated (TOTAL_BLOCKS at its default).
  localparam int MAP_BITS = 1024;

  typedef struct packed {
    status_t          status;
    logic [BLK_W-1:0] granted_block;
  } alloc_result_t;

  logic [MAP_BITS-1:0] used_map;
  logic [BLK_W-1:0]    start_reg;
  logic [CNT_W-1:0]    count_reg;
  alloc_result_t       due_results[$];
  int                  err_cnt;

  function automatic int tracked_blocks();
    int lim;
    lim = int'(count_reg);
    if (lim > MAP_BITS) lim = MAP_BITS;
    if (lim > BLOCK_LIMIT - int'(start_reg)) lim = BLOCK_LIMIT - int'(start_reg);
    return lim;
  endfunction

  // Applies one request to the map and returns the result the block must give.
  function automatic alloc_result_t apply_request(logic rtype, logic [BLK_W-1:0] num);
    alloc_result_t r;
    int n;
    int idx;
    int off;
    r.status        = STAT_OK;
    r.granted_block = '0;
    n = tracked_blocks();
    if (rtype == REQ_ALLOC) begin
      idx = 0;
      while (idx < n && used_map[idx]) idx++;
      if (idx < n) begin
        used_map[idx]   = 1'b1;
        r.granted_block = BLK_W'(int'(start_reg) + idx);
      end else begin
        r.status = STAT_FULL;
      end
    end else begin
      off = int'(num) - int'(start_reg);
      if (off < 0 || off >= n) r.status = STAT_RANGE;
      else used_map[off] = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst_n) begin
      used_map  = '0;
      start_reg = DATA_START_RST;
      count_reg = DATA_COUNT_RST;
      due_results.delete();
      err_cnt = 0;
    end else begin
      if (cfg.valid === 1'b1 && cfg.ready === 1'b1) begin
        case (cfg.index)
          CFG_DATA_START: start_reg = cfg.data[BLK_W-1:0];
          CFG_DATA_COUNT: count_reg = cfg.data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (due_results.size() == 0) begin
          $error("result with no request waiting: status %0d, granted_block %0d",
                 rsp.status, rsp.granted_block);
          err_cnt++;
        end else begin
          exp_r = due_results.pop_front();
          if (rsp.status !== exp_r.status) begin
            $error("status: expected %0d, actual %0d", exp_r.status, rsp.status);
            err_cnt++;
          end
          if (rsp.granted_block !== exp_r.granted_block) begin
            $error("granted_block: expected %0d, actual %0d",
                   exp_r.granted_block, rsp.granted_block);
            err_cnt++;
          end
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1)
        due_results.insert(due_results.size(), apply_request(req.req_type, req.block_num));
    end
    outstanding <= due_results.size();
    mismatches  <= err_cnt;
  end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the allocator testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import bbalc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int IDLE_LIMIT    = 5000;
  localparam int HOLDOFF_LEN   = 300;
  localparam int NUM_PHASES    = 12;
  localparam int PHASE_ITEMS   = 120;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_PERIODIC} rdy_mode_t;

  logic clk;
  logic rst_n;

  bbalc_req_if in_chan();
  bbalc_rsp_if out_chan();
  bbalc_cfg_if cfg_chan();

  int mismatches;
  int outstanding;

  logic [BLK_W-1:0] cur_start;
  logic [CNT_W-1:0] cur_count;
  int               burst_left;
  int               holdoff_reqs;

  bitmap_block_allocator_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  bbalc_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (in_chan),
    .rsp         (out_chan),
    .cfg         (cfg_chan),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int tracked_now();
    int lim;
    lim = int'(cur_count);
    if (lim > BLOCK_LIMIT) lim = BLOCK_LIMIT;
    if (lim > BLOCK_LIMIT - int'(cur_start)) lim = BLOCK_LIMIT - int'(cur_start);
    return lim;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= d;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
    if (idx == CFG_DATA_START) cur_start = d[BLK_W-1:0];
    else if (idx == CFG_DATA_COUNT) cur_count = d[CNT_W-1:0];
  endtask

  // Offers one request and returns once it has been taken; bursts and gaps live here.
  task automatic send_req(input logic rtype, input logic [BLK_W-1:0] num);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25) : $urandom_range(1, 6);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_chan.valid     <= 1'b1;
    in_chan.req_type  <= rtype;
    in_chan.block_num <= num;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic random_req(input int alloc_pct);
    int r;
    int n;
    logic [BLK_W-1:0] num;
    r = $urandom_range(0, 99);
    n = tracked_now();
    if (r < alloc_pct) begin
      send_req(REQ_ALLOC, BLK_W'($urandom));
    end else if (r < alloc_pct + (100 - alloc_pct) * 3 / 4 && n > 0) begin
      send_req(REQ_FREE, BLK_W'(int'(cur_start) + int'($urandom_range(0, n - 1))));
    end else begin
      case ($urandom_range(0, 2))
        0:       num = cur_start - 1'b1;
        1:       num = BLK_W'(int'(cur_start) + n);
        default: num = BLK_W'($urandom);
      endcase
      send_req(REQ_FREE, num);
    end
  endtask

  // Receiver: changing stall patterns, plus a long hold-off whenever one is asked for.
  initial begin
    rdy_mode_t mode;
    int stretch_left;
    int period;
    int hold_left;
    int seen;
    logic rdy;
    stretch_left = 0;
    period = 2;
    hold_left = 0;
    seen = 0;
    mode = RDY_ALWAYS;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (seen != holdoff_reqs) begin
        seen = holdoff_reqs;
        hold_left = HOLDOFF_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (stretch_left == 0) begin
          mode = rdy_mode_t'($urandom_range(0, 3));
          stretch_left = $urandom_range(8, 64);
          period = $urandom_range(2, 5);
        end
        stretch_left--;
        case (mode)
          RDY_ALWAYS:   rdy = 1'b1;
          RDY_COIN:     rdy = 1'($urandom_range(0, 1));
          RDY_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
          default:      rdy = ((stretch_left % period) == 0);
        endcase
      end
      out_chan.ready <= rdy;
    end
  end

  // Watchdog: ends the run when no channel has moved anything for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
          (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) ||
          (cfg_chan.valid === 1'b1 && cfg_chan.ready === 1'b1))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int alloc_pct;
    logic [BLK_W-1:0] st;
    logic [CNT_W-1:0] cnt;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.req_type   = REQ_ALLOC;
    in_chan.block_num  = '0;
    cfg_chan.valid     = 1'b0;
    cfg_chan.index     = CFG_DATA_START;
    cfg_chan.data      = '0;
    cur_start          = DATA_START_RST;
    cur_count          = DATA_COUNT_RST;
    burst_left         = 0;
    holdoff_reqs       = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: first fit, double free, lowest and highest tracked block.
    send_req(REQ_ALLOC, 10'd0);
    send_req(REQ_ALLOC, 10'd0);
    send_req(REQ_FREE, 10'd10);
    send_req(REQ_FREE, 10'd10);
    send_req(REQ_ALLOC, 10'h3FF);
    send_req(REQ_FREE, 10'd9);
    send_req(REQ_FREE, 10'd1023);
    send_req(REQ_FREE, 10'd0);
    send_req(REQ_ALLOC, 10'h3FF);
    wait_drained();

    // Nothing tracked; the start write carries a set bit above its field.
    write_reg(CFG_DATA_START, 11'h400);
    write_reg(CFG_DATA_COUNT, 11'd0);
    write_reg(CFG_SPARE_2, 11'h7FF);
    write_reg(CFG_SPARE_3, 11'h155);
    send_req(REQ_ALLOC, 10'd0);
    send_req(REQ_FREE, 10'd0);
    send_req(REQ_FREE, 10'd1023);
    wait_drained();

    // Count saturates at a single block, the top one at start 1023.
    write_reg(CFG_DATA_START, 11'd1023);
    write_reg(CFG_DATA_COUNT, 11'd2047);
    send_req(REQ_ALLOC, 10'd0);
    send_req(REQ_ALLOC, 10'd0);
    send_req(REQ_FREE, 10'd1023);
    send_req(REQ_FREE, 10'd1022);
    send_req(REQ_ALLOC, 10'd0);
    wait_drained();

    // Whole map tracked.
    write_reg(CFG_DATA_START, 11'd0);
    write_reg(CFG_DATA_COUNT, 11'd1024);
    send_req(REQ_ALLOC, 10'd0);
    send_req(REQ_FREE, 10'd0);
    send_req(REQ_FREE, 10'd1023);
    send_req(REQ_ALLOC, 10'd0);
    wait_drained();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin st = 10'd0;    cnt = 11'd1024; end
        1: begin st = 10'd1000; cnt = 11'd2047; end
        2: begin st = 10'd1023; cnt = 11'd1;    end
        3: begin st = 10'd5;    cnt = 11'd40;   end
        4: begin st = 10'd300;  cnt = 11'd0;    end
        default: begin
          st = BLK_W'($urandom);
          cnt = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 2047))
                                            : CNT_W'($urandom_range(1, 64));
        end
      endcase
      write_reg(CFG_DATA_START, {1'($urandom_range(0, 1)), st});
      write_reg(CFG_DATA_COUNT, cnt);
      if (ph % 3 == 0) write_reg(($urandom_range(0, 1) != 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                                 CFG_DATA_W'($urandom));
      alloc_pct = $urandom_range(35, 75);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // The receiver stops for a long stretch while requests keep coming.
        if ((ph == 3 || ph == 8) && k == 30) holdoff_reqs <= holdoff_reqs + 1;
        if (ph == 6 && k == 60) wait_drained();
        random_req(alloc_pct);
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
